// File: sv/pwbb_pkg.sv
// shared types, constants and helpers of the per-type window byte budget block
`timescale 1ns / 1ps
package pwbb_pkg;

   localparam int unsigned TYPE_SLOTS_DEF = 131072;
   localparam logic [15:0] BUDGET_RST     = 16'd2048;
   localparam logic [7:0]  HEADER_RST     = 8'd12;
   localparam logic [16:0] MAX_TYPE_RST   = 17'd100000;

   localparam int unsigned DIVIDEND_W = 48;
   localparam int unsigned DIVISOR_W  = 32;

   localparam logic [1:0] REG_BUDGET   = 2'd0;
   localparam logic [1:0] REG_HEADER   = 2'd1;
   localparam logic [1:0] REG_MAX_TYPE = 2'd2;

   localparam logic CMD_MSG    = 1'b0;
   localparam logic CMD_REPORT = 1'b1;

   typedef struct packed {
      logic        valid;
      logic [31:0] epoch;
      logic [15:0] free;
      logic [15:0] msgs;
      logic [31:0] saved;
   } entry_type;

   // lowest field last
   typedef struct packed {
      logic        no_windows;
      logic [47:0] average;
      logic [31:0] window_total;
      logic [31:0] saved_total;
      logic        present;
      logic        ignored;
      logic        accepted;
   } result_type;

   function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [15:0] b);
      logic [32:0] s;
      s = {1'b0, a} + {17'b0, b};
      return s[32] ? 32'hFFFF_FFFF : s[31:0];
   endfunction

endpackage

// File: sv/pwbb_table.sv
// per-type entry memory, one write port and one registered read port
`timescale 1ns / 1ps
module pwbb_table #(
   parameter int unsigned TYPE_SLOTS = pwbb_pkg::TYPE_SLOTS_DEF
) (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [$clog2(TYPE_SLOTS)-1:0] wr_addr,
   input  pwbb_pkg::entry_type           wr_data,
   input  logic                          rd_en,
   input  logic [$clog2(TYPE_SLOTS)-1:0] rd_addr,
   output pwbb_pkg::entry_type           rd_data
);

   pwbb_pkg::entry_type mem [TYPE_SLOTS];
   pwbb_pkg::entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sv/pwbb_div.sv
// restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
module pwbb_div (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [pwbb_pkg::DIVIDEND_W-1:0]   dividend,
   input  logic [pwbb_pkg::DIVISOR_W-1:0]    divisor,
   output logic                              busy,
   output logic                              done,
   output logic [pwbb_pkg::DIVIDEND_W-1:0]   quotient
);

   localparam int unsigned CW = $clog2(pwbb_pkg::DIVIDEND_W);

   logic [pwbb_pkg::DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [pwbb_pkg::DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [pwbb_pkg::DIVISOR_W-1:0]  dsr_ff;
   logic [CW-1:0]                   cnt_ff, cnt_in;
   logic                            busy_ff, busy_in;
   logic                            done_ff, done_in;
   logic [pwbb_pkg::DIVISOR_W:0]    trial;
   logic                            fits;

   assign trial = {rem_ff, quo_ff[pwbb_pkg::DIVIDEND_W-1]};
   assign fits  = trial >= {1'b0, dsr_ff};

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? pwbb_pkg::DIVISOR_W'(trial - {1'b0, dsr_ff})
                       : trial[pwbb_pkg::DIVISOR_W-1:0];
         quo_in = {quo_ff[pwbb_pkg::DIVIDEND_W-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CW'(pwbb_pkg::DIVIDEND_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      cnt_ff <= cnt_in;
      if (start) begin
         dsr_ff <= divisor;
      end
   end

   assign busy     = busy_ff;
   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// File: sv/per_type_window_byte_budget_top.sv
// top level of the per-type window byte budget policer
//
//  port group | dir | contents
//  req_*      | in  | tuser: cmd; tdata: msg_type, stamp, payload_len
//  rsp_*      | out | tdata: accepted, ignored, present, saved_total,
//             |     |        window_total, average, no_windows
//  csr_*      | in  | 0 budget_bytes, 1 header_bytes, 2 max_type
//
// after reset the entry table is swept, one entry a cycle, with req_tready low;
// csr writes are taken during the sweep.
// a message is a table read, then update and write back.
// a report reads the table, then runs the 48-step divider; with no windows it skips it.
// the result sits in an output register, a stalled rsp holds the sequencer.
`timescale 1ns / 1ps
module per_type_window_byte_budget_top #(
   parameter int unsigned TYPE_SLOTS = pwbb_pkg::TYPE_SLOTS_DEF
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic          req_tuser,   // cmd
   input  logic [95:0]   req_tdata,   // msg_type, stamp, payload_len
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [119:0]  rsp_tdata,   // accepted, ignored, present, saved_total,
                                      // window_total, average, no_windows
   input  logic          csr_we,
   input  logic [1:0]    csr_addr,
   input  logic [16:0]   csr_wdata
);

   localparam int unsigned AW = $clog2(TYPE_SLOTS);

   typedef enum logic [4:0] {
      ST_CLEAR = 5'b00001,
      ST_IDLE  = 5'b00010,
      ST_EXEC  = 5'b00100,
      ST_DIV   = 5'b01000,
      ST_HOLD  = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   logic [15:0] budget_ff;
   logic [7:0]  header_ff;
   logic [16:0] max_type_ff;
   logic [31:0] last_stamp_ff, last_stamp_in;
   logic [31:0] win_cnt_ff, win_cnt_in;
   logic        cmd_ff;
   logic [31:0] type_ff;
   logic [31:0] len_ff;
   logic        ign_ff;
   logic [AW-1:0] clr_addr_ff;
   logic        rsp_valid_ff, rsp_valid_in;
   pwbb_pkg::result_type rsp_data_ff, rsp_data_in;
   pwbb_pkg::result_type hold_ff, hold_in;
   logic        present_ff, present_in;
   logic [31:0] total_ff, total_in;

   logic [31:0] in_type, in_stamp, in_len;
   logic        accept, in_ign, slot_free;
   logic        tbl_we;
   logic [AW-1:0] tbl_waddr;
   pwbb_pkg::entry_type tbl_wdata, rd, upd;
   logic [32:0] cost;
   logic        fits, fresh;
   logic        div_start, div_busy, div_done;
   logic [47:0] quotient;
   pwbb_pkg::result_type res;
   logic        res_load;

   assign in_type  = req_tdata[31:0];
   assign in_stamp = req_tdata[63:32];
   assign in_len   = req_tdata[95:64];

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign slot_free  = !rsp_valid_ff || rsp_tready;

   always_comb begin
      in_ign = in_type >= 32'(TYPE_SLOTS);
      if (req_tuser == pwbb_pkg::CMD_MSG && in_type > {15'b0, max_type_ff}) begin
         in_ign = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         budget_ff   <= pwbb_pkg::BUDGET_RST;
         header_ff   <= pwbb_pkg::HEADER_RST;
         max_type_ff <= pwbb_pkg::MAX_TYPE_RST;
      end else if (csr_we) begin
         unique case (csr_addr)
            pwbb_pkg::REG_BUDGET:   budget_ff   <= csr_wdata[15:0];
            pwbb_pkg::REG_HEADER:   header_ff   <= csr_wdata[7:0];
            pwbb_pkg::REG_MAX_TYPE: max_type_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   pwbb_table #(.TYPE_SLOTS(TYPE_SLOTS)) u_table (
      .clock   (clock),
      .wr_en   (tbl_we),
      .wr_addr (tbl_waddr),
      .wr_data (tbl_wdata),
      .rd_en   (accept),
      .rd_addr (in_type[AW-1:0]),
      .rd_data (rd)
   );

   // bring the entry into the current window, then charge the message
   always_comb begin
      upd   = rd;
      fresh = 1'b1;
      if (!rd.valid) begin
         upd.saved = '0;
      end else if (rd.epoch == win_cnt_ff) begin
         fresh = 1'b0;
      end else begin
         upd.saved = pwbb_pkg::sat_add(rd.saved, rd.msgs);
      end
      upd.valid = 1'b1;
      if (fresh) begin
         upd.epoch = win_cnt_ff;
         upd.free  = budget_ff;
         upd.msgs  = '0;
      end
      cost = {25'b0, header_ff} + {1'b0, len_ff};
      fits = {17'b0, upd.free} > cost;
      if (fits) begin
         upd.free = upd.free - cost[15:0];
         if (upd.msgs != 16'hFFFF) begin
            upd.msgs = upd.msgs + 16'd1;
         end
      end
   end

   always_comb begin
      tbl_we    = 1'b0;
      tbl_waddr = type_ff[AW-1:0];
      tbl_wdata = upd;
      if (state_ff == ST_CLEAR) begin
         tbl_we    = 1'b1;
         tbl_waddr = clr_addr_ff;
         tbl_wdata = '0;
      end else if (state_ff == ST_EXEC && cmd_ff == pwbb_pkg::CMD_MSG && !ign_ff) begin
         tbl_we = 1'b1;
      end
   end

   pwbb_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend ({total_in, 16'b0}),
      .divisor  (win_cnt_ff),
      .busy     (div_busy),
      .done     (div_done),
      .quotient (quotient)
   );

   always_comb begin
      state_in      = state_ff;
      last_stamp_in = last_stamp_ff;
      win_cnt_in    = win_cnt_ff;
      present_in    = present_ff;
      total_in      = total_ff;
      hold_in       = hold_ff;
      div_start     = 1'b0;
      res           = '0;
      res_load      = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clr_addr_ff == AW'(TYPE_SLOTS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_EXEC;
               if (req_tuser == pwbb_pkg::CMD_MSG && !in_ign
                   && in_stamp != last_stamp_ff) begin
                  last_stamp_in = in_stamp;
                  win_cnt_in    = win_cnt_ff + 32'd1;
               end
            end
         end
         ST_EXEC: begin
            if (cmd_ff == pwbb_pkg::CMD_MSG) begin
               res.ignored  = ign_ff;
               res.accepted = !ign_ff && fits;
               res_load     = 1'b1;
            end else begin
               present_in = !ign_ff && rd.valid;
               total_in   = present_in ? pwbb_pkg::sat_add(rd.saved, rd.msgs) : '0;
               res.ignored      = ign_ff;
               res.present      = present_in;
               res.saved_total  = total_in;
               res.window_total = win_cnt_ff;
               if (win_cnt_ff == '0) begin
                  res.no_windows = 1'b1;
                  res.average    = '1;
                  res_load       = 1'b1;
               end else begin
                  div_start = 1'b1;
                  state_in  = ST_DIV;
               end
            end
         end
         ST_DIV: begin
            if (div_done) begin
               res.ignored      = ign_ff;
               res.present      = present_ff;
               res.saved_total  = total_ff;
               res.window_total = win_cnt_ff;
               res.average      = quotient;
               res_load         = 1'b1;
            end
         end
         ST_HOLD: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      if (res_load) begin
         hold_in  = res;
         state_in = slot_free ? ST_IDLE : ST_HOLD;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      if (res_load && slot_free) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res;
      end else if (state_ff == ST_HOLD && slot_free) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = hold_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_addr_ff   <= '0;
         last_stamp_ff <= '0;
         win_cnt_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_addr_ff   <= clr_addr_ff + 1'b1;
         last_stamp_ff <= last_stamp_in;
         win_cnt_ff    <= win_cnt_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
      hold_ff     <= hold_in;
      present_ff  <= present_in;
      total_ff    <= total_in;
      if (accept) begin
         cmd_ff  <= req_tuser;
         type_ff <= in_type;
         len_ff  <= in_len;
         ign_ff  <= in_ign;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0, rsp_data_ff};

   a_no_accept_in_sweep : assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CLEAR |-> !req_tready)
      else $error("input taken during table sweep");

   a_div_only_in_div : assert property (@(posedge clock) disable iff (reset)
      div_busy |-> state_ff == ST_DIV)
      else $error("divider running outside report state");

   a_sat_on_no_windows : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.no_windows |-> rsp_data_ff.average == '1)
      else $error("average not saturated with no windows");

   a_accept_not_ignored : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_data_ff.accepted && rsp_data_ff.ignored))
      else $error("word both accepted and ignored");

endmodule

// File: tb/testbench.sv
// self-checking testbench for the per-type window byte budget policer
`timescale 1ns / 1ps
module testbench;

   localparam int unsigned SLOTS = pwbb_pkg::TYPE_SLOTS_DEF;
   localparam int unsigned CYCLE_LIMIT = 2000000;

   logic          clock;
   logic          reset;
   logic          req_tvalid;
   logic          req_tready;
   logic          req_tuser;    // cmd
   logic [95:0]   req_tdata;    // msg_type, stamp, payload_len
   logic          rsp_tvalid;
   logic          rsp_tready;
   logic [119:0]  rsp_tdata;    // accepted, ignored, present, saved_total,
                                // window_total, average, no_windows
   logic          csr_we;
   logic [1:0]    csr_addr;
   logic [16:0]   csr_wdata;

   per_type_window_byte_budget_top DUT (.*);

   // policer state as the block should hold it
   logic [15:0] budget_bytes;
   logic [7:0]  header_bytes;
   logic [16:0] max_type;
   logic [31:0] last_stamp;
   logic [31:0] window_count;
   pwbb_pkg::entry_type entries [int unsigned];

   pwbb_pkg::result_type expected_words [$];
   int          idle_pct;
   int          stall_pct;
   int          errors;
   int          cycles;
   logic [31:0] cur_stamp;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("[per_type_window_byte_budget_top] ERROR");
         $finish;
      end
   end

   function automatic logic [31:0] add_sat(logic [31:0] a, logic [15:0] b);
      logic [32:0] s;
      s = {1'b0, a} + {17'd0, b};
      return s[32] ? 32'hFFFF_FFFF : s[31:0];
   endfunction

   // window and budget bookkeeping for one accepted word
   function automatic pwbb_pkg::result_type policer_outcome(logic cmd, logic [31:0] t,
                                                  logic [31:0] stamp, logic [31:0] len);
      pwbb_pkg::result_type r;
      pwbb_pkg::entry_type  e;
      logic [63:0] cost;
      logic [31:0] total;
      r = '0;
      if (cmd == pwbb_pkg::CMD_MSG) begin
         if (t > {15'd0, max_type} || t >= SLOTS) begin
            r.ignored = 1'b1;
            return r;
         end
         if (stamp != last_stamp) begin
            last_stamp = stamp;
            window_count = window_count + 32'd1;
         end
         if (!entries.exists(t)) begin
            e.valid = 1'b1;
            e.saved = '0;
            e.epoch = window_count;
            e.free  = budget_bytes;
            e.msgs  = '0;
         end else begin
            e = entries[t];
            if (e.epoch != window_count) begin
               e.saved = add_sat(e.saved, e.msgs);
               e.epoch = window_count;
               e.free  = budget_bytes;
               e.msgs  = '0;
            end
         end
         cost = {56'd0, header_bytes} + {32'd0, len};
         if ({48'd0, e.free} > cost) begin
            e.free = e.free - cost[15:0];
            if (e.msgs != 16'hFFFF) e.msgs = e.msgs + 16'd1;
            r.accepted = 1'b1;
         end
         entries[t] = e;
         return r;
      end
      total = '0;
      if (t >= SLOTS) r.ignored = 1'b1;
      else if (entries.exists(t)) begin
         r.present = 1'b1;
         total = add_sat(entries[t].saved, entries[t].msgs);
      end
      r.saved_total  = total;
      r.window_total = window_count;
      if (window_count == 0) begin
         r.average = '1;
         r.no_windows = 1'b1;
      end else begin
         r.average = 48'(({32'd0, total} << 16) / {32'd0, window_count});
      end
      return r;
   endfunction

   task automatic send_word(logic cmd, logic [31:0] t, logic [31:0] stamp,
                            logic [31:0] len);
      if ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < idle_pct);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {len, stamp, t};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      expected_words.push_back(policer_outcome(cmd, t, stamp, len));
   endtask

   task automatic drain;
      @(posedge clock);
      req_tvalid <= 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   task automatic write_csr(logic [1:0] addr, logic [16:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      case (addr)
         pwbb_pkg::REG_BUDGET:   budget_bytes = value[15:0];
         pwbb_pkg::REG_HEADER:   header_bytes = value[7:0];
         pwbb_pkg::REG_MAX_TYPE: max_type     = value;
         default: ;
      endcase
   endtask

   task automatic set_policy(logic [15:0] budget, logic [7:0] hdr, logic [16:0] maxt);
      write_csr(pwbb_pkg::REG_BUDGET, {1'b0, budget});
      write_csr(pwbb_pkg::REG_HEADER, {9'd0, hdr});
      write_csr(pwbb_pkg::REG_MAX_TYPE, maxt);
   endtask

   // result checker
   task automatic check_field(string name, logic [63:0] exp, logic [63:0] act);
      if (exp !== act) begin
         errors++;
         $display("%0t %s mismatch: expected %0h actual %0h", $time, name, exp, act);
      end
   endtask

   always @(posedge clock) begin
      pwbb_pkg::result_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[115:0];
         if (expected_words.size() == 0) begin
            errors++;
            $display("%0t unexpected word: expected none actual %0h", $time, got);
         end else begin
            want = expected_words.pop_front();
            check_field("accepted", 64'(want.accepted), 64'(got.accepted));
            check_field("ignored", 64'(want.ignored), 64'(got.ignored));
            check_field("present", 64'(want.present), 64'(got.present));
            check_field("saved_total", 64'(want.saved_total), 64'(got.saved_total));
            check_field("window_total", 64'(want.window_total), 64'(got.window_total));
            check_field("average", 64'(want.average), 64'(got.average));
            check_field("no_windows", 64'(want.no_windows), 64'(got.no_windows));
         end
      end
      rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   task automatic test_first_window;
      send_word(pwbb_pkg::CMD_REPORT, 32'd5, 32'd0, 32'd0);     // nothing opened yet
      send_word(pwbb_pkg::CMD_MSG, 32'd3, 32'd0, 32'd10);       // stamp zero, no window
      send_word(pwbb_pkg::CMD_REPORT, 32'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_word(pwbb_pkg::CMD_MSG, 32'd100001, 32'd1, 32'd0);   // above max_type
      send_word(pwbb_pkg::CMD_REPORT, 32'd131072, 32'd0, 32'd0);
      send_word(pwbb_pkg::CMD_REPORT, 32'hFFFF_FFFF, 32'd0, 32'd0);
      send_word(pwbb_pkg::CMD_MSG, 32'hFFFF_FFFF, 32'd1, 32'd1);
      send_word(pwbb_pkg::CMD_MSG, 32'd3, 32'd7, 32'd2035);     // cost 2047 just fits
      send_word(pwbb_pkg::CMD_MSG, 32'd3, 32'd7, 32'd0);
      send_word(pwbb_pkg::CMD_MSG, 32'd0, 32'd7, 32'hFFFF_FFFF);
      send_word(pwbb_pkg::CMD_MSG, 32'd4, 32'd7, 32'd2036);     // cost equals budget
      send_word(pwbb_pkg::CMD_MSG, 32'd3, 32'd8, 32'd1);
      send_word(pwbb_pkg::CMD_REPORT, 32'd3, 32'd0, 32'd0);
      send_word(pwbb_pkg::CMD_REPORT, 32'd4, 32'd0, 32'd0);
      drain();
   endtask

   task automatic test_policy_extremes;
      set_policy(16'hFFFF, 8'hFF, 17'h1FFFF);
      send_word(pwbb_pkg::CMD_MSG, 32'd131071, 32'd9, 32'd0);
      send_word(pwbb_pkg::CMD_MSG, 32'd131072, 32'd9, 32'd0);
      send_word(pwbb_pkg::CMD_MSG, 32'd3, 32'd9, 32'd65279);
      send_word(pwbb_pkg::CMD_REPORT, 32'd131071, 32'd0, 32'd0);
      drain();
      set_policy(16'd0, 8'd0, 17'd0);
      send_word(pwbb_pkg::CMD_MSG, 32'd1, 32'd10, 32'd0);
      send_word(pwbb_pkg::CMD_MSG, 32'd0, 32'd10, 32'd0);       // empty budget refuses all
      send_word(pwbb_pkg::CMD_REPORT, 32'd1, 32'd0, 32'd0);
      send_word(pwbb_pkg::CMD_REPORT, 32'd0, 32'd0, 32'd0);
      drain();
   endtask

   task automatic test_random_traffic(int count);
      logic [31:0] t, len;
      logic        cmd;
      for (int i = 0; i < count; i++) begin
         cmd = ($urandom_range(99) < 15) ? pwbb_pkg::CMD_REPORT : pwbb_pkg::CMD_MSG;
         case ($urandom_range(9))
            0:       t = $urandom;
            1:       t = {15'd0, max_type} + $urandom_range(2) - 1;
            default: t = $urandom_range(15);
         endcase
         case ($urandom_range(19))
            0:       cur_stamp = $urandom;
            1, 2, 3: cur_stamp = cur_stamp + 1;
            default: ;
         endcase
         len = ($urandom_range(19) == 0) ? $urandom : $urandom_range(300);
         send_word(cmd, t, cur_stamp, len);
      end
      drain();
   endtask

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tuser  = 1'b0;
      req_tdata  = '0;
      rsp_tready = 1'b0;
      csr_we     = 1'b0;
      csr_addr   = '0;
      csr_wdata  = '0;
      errors = 0;
      cycles = 0;
      idle_pct = 0;
      stall_pct = 0;
      cur_stamp = 32'd100;
      budget_bytes = pwbb_pkg::BUDGET_RST;
      header_bytes = pwbb_pkg::HEADER_RST;
      max_type     = pwbb_pkg::MAX_TYPE_RST;
      last_stamp   = '0;
      window_count = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      test_first_window();
      test_policy_extremes();

      idle_pct = 24; stall_pct = 74;
      set_policy(16'd1024, 8'd12, 17'd12);
      test_random_traffic(580);
      idle_pct = 74; stall_pct = 24;
      set_policy(16'd400, 8'd0, 17'd131071);
      test_random_traffic(580);
      idle_pct = 0; stall_pct = 0;
      set_policy(16'($urandom_range(65535)), 8'($urandom_range(255)), 17'd9);
      test_random_traffic(580);

      if (errors == 0) begin
         $display("[per_type_window_byte_budget_top] OK");
      end else begin
         $display("[per_type_window_byte_budget_top] ERROR");
      end
      $finish;
   end

endmodule

// File: files.f
sv/pwbb_pkg.sv
sv/pwbb_table.sv
sv/pwbb_div.sv
sv/per_type_window_byte_budget_top.sv
tb/testbench.sv
